FILE: design/set_assoc_cache_tag_controller_macros.svh
// Assertion macros shared by the cache tag controller modules.
// Needs only a clock and reset in the including scope.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
// implication checked every clock outside reset
`define SACT_ASSERT_IMP(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SACT_ASSERT_NXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");
`endif

FILE: design/sact_pkg.sv
// Package for the cache tag controller: line states, register indexes, opcodes.
// No dependencies.
`default_nettype none
package sact_pkg;
   typedef enum logic [1:0] {
      ST_INVALID = 2'd0,
      ST_CLEAN   = 2'd1,
      ST_DIRTY   = 2'd2
   } line_state_type;

   localparam logic [1:0] REG_READ_LAT  = 2'd0;
   localparam logic [1:0] REG_WRITE_LAT = 2'd1;
   localparam logic [1:0] REG_MISS_PEN  = 2'd2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam int LAT_BITS = 10;
   localparam logic [LAT_BITS-1:0] RESET_READ_LAT  = 10'd1;
   localparam logic [LAT_BITS-1:0] RESET_WRITE_LAT = 10'd1;
   localparam logic [LAT_BITS-1:0] RESET_MISS_PEN  = 10'd200;

   // latency configuration handed from register block to the pipeline
   typedef struct packed {
      logic [LAT_BITS-1:0] read_lat;
      logic [LAT_BITS-1:0] write_lat;
      logic [LAT_BITS-1:0] miss_pen;
   } lat_cfg_type;
endpackage
`default_nettype wire

FILE: design/sact_if.sv
// Request and response channel interfaces of the cache tag controller.
// No dependencies.
`default_nettype none
interface sact_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  core_id;
   logic [47:0] byte_address;
   logic        opcode;
   modport source (output valid, core_id, byte_address, opcode, input ready);
   modport sink (input valid, core_id, byte_address, opcode, output ready);
endinterface

interface sact_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [2:0]  way_used;
   logic        writeback_valid;
   logic [47:0] writeback_address;
   logic [3:0]  writeback_core;
   logic        fill_valid;
   logic [47:0] fill_address;
   logic [10:0] latency;
   modport source (output valid, hit, way_used, writeback_valid, writeback_address,
      writeback_core, fill_valid, fill_address, latency, input ready);
   modport sink (input valid, hit, way_used, writeback_valid, writeback_address,
      writeback_core, fill_valid, fill_address, latency, output ready);
endinterface
`default_nettype wire

FILE: design/sact_csr.sv
// Configuration registers of the cache tag controller, APB-style write/read.
// Depends on sact_pkg.
`default_nettype none
module sact_csr
   import sact_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output lat_cfg_type      cfg
);
   lat_cfg_type cfg_ff;
   logic [1:0]  idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_lat  <= RESET_READ_LAT;
         cfg_ff.write_lat <= RESET_WRITE_LAT;
         cfg_ff.miss_pen  <= RESET_MISS_PEN;
      end else if (wr_en && paddr[1:0] == 2'b00) begin
         unique case (idx)
            REG_READ_LAT:  cfg_ff.read_lat  <= pwdata[LAT_BITS-1:0];
            REG_WRITE_LAT: cfg_ff.write_lat <= pwdata[LAT_BITS-1:0];
            REG_MISS_PEN:  cfg_ff.miss_pen  <= pwdata[LAT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      prdata = 32'd0;
      unique case (idx)
         REG_READ_LAT:  prdata = {22'd0, cfg_ff.read_lat};
         REG_WRITE_LAT: prdata = {22'd0, cfg_ff.write_lat};
         REG_MISS_PEN:  prdata = {22'd0, cfg_ff.miss_pen};
         default:       prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

FILE: design/sact_pipe.sv
// Tag lookup pipeline: set memory, way compare, victim choice, LRU update.
// Depends on sact_pkg and the macros header.
`default_nettype none
`include "set_assoc_cache_tag_controller_macros.svh"
module sact_pipe
   import sact_pkg::*;
#(
   parameter int SETS       = 64,
   parameter int WAYS       = 8,
   parameter int LINE_BYTES = 64,
   parameter int ADDR_BITS  = 48
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  lat_cfg_type cfg,
   sact_req_if.sink   req,
   sact_rsp_if.source rsp
);
   localparam int LB  = $clog2(LINE_BYTES + 1) - 1;
   localparam int SB  = $clog2(SETS + 1) - 1;
   localparam int SI  = (SB > 0) ? SB : 1;
   localparam int TB  = ADDR_BITS - LB - SB;
   localparam int WB  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NS  = 1 << SB;

   // memory entry per way: tag, owner, state, rank
   typedef struct packed {
      logic [TB-1:0] tag;
      logic [3:0]    owner;
      logic [1:0]    st;
      logic [WB-1:0] rank;
   } way_ent_type;
   typedef way_ent_type [WAYS-1:0] set_ent_type;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_RESP} state_type;

   state_type     state_ff;
   logic [SI-1:0] clr_ff;
   logic [SI-1:0] set_ff;
   logic [TB-1:0] tag_ff;
   logic [3:0]    core_ff;
   logic          wr_ff;
   set_ent_type   mem [NS];
   set_ent_type   rd_ff;

   logic [ADDR_BITS-1:0] addr_m;
   logic [SI-1:0]        set_in;
   set_ent_type          reset_set;
   set_ent_type          new_set;
   logic                 hit_c, wb_c;
   logic [WB-1:0]        way_c;
   logic [10:0]          lat_c;
   logic [47:0]          wb_addr_c, fill_addr_c;

   assign addr_m = ADDR_BITS'(req.byte_address);
   always_comb begin
      set_in = '0;
      if (SB > 0) set_in = SI'(addr_m >> LB);
   end

   // reset content of one set: invalid, rank equals way index
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         reset_set[w]      = '0;
         reset_set[w].rank = WB'(w);
      end
   end

   // way compare, victim choice and update of the read set
   always_comb begin
      logic [WB-1:0] old_rank;
      logic [ADDR_BITS-1:0] wa, fa;
      hit_c = 1'b0; way_c = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_ff[w].st != ST_INVALID && rd_ff[w].tag == tag_ff &&
             rd_ff[w].owner == core_ff) begin
            hit_c = 1'b1; way_c = WB'(w);
         end
      end
      if (!hit_c) begin
         for (int w = WAYS - 1; w >= 0; w--)
            if (rd_ff[w].rank == '0) way_c = WB'(w);
         for (int w = WAYS - 1; w >= 0; w--)
            if (rd_ff[w].st == ST_INVALID) way_c = WB'(w);
      end
      wb_c = !hit_c && rd_ff[way_c].st == ST_DIRTY;
      wa = ADDR_BITS'({rd_ff[way_c].tag, set_ff[SI-1:0]}) << LB;
      if (SB == 0) wa = ADDR_BITS'(rd_ff[way_c].tag) << LB;
      fa = ADDR_BITS'({tag_ff, set_ff}) << LB;
      if (SB == 0) fa = ADDR_BITS'(tag_ff) << LB;
      wb_addr_c   = wb_c ? 48'(wa) : 48'd0;
      fill_addr_c = hit_c ? 48'd0 : 48'(fa);
      lat_c = {1'b0, wr_ff ? cfg.write_lat : cfg.read_lat} +
              (hit_c ? 11'd0 : {1'b0, cfg.miss_pen});
      old_rank = rd_ff[way_c].rank;
      new_set  = rd_ff;
      for (int w = 0; w < WAYS; w++)
         if (rd_ff[w].rank > old_rank) new_set[w].rank = rd_ff[w].rank - 1'b1;
      new_set[way_c].rank = WB'(WAYS - 1);
      if (!hit_c) begin
         new_set[way_c].tag   = tag_ff;
         new_set[way_c].owner = core_ff;
         new_set[way_c].st    = wr_ff ? ST_DIRTY : ST_CLEAN;
      end else if (wr_ff) begin
         new_set[way_c].st = ST_DIRTY;
      end
   end

   assign req.ready = (state_ff == S_IDLE);

   // set memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) mem[clr_ff] <= reset_set;
      else if (state_ff == S_LOOK) mem[set_ff] <= new_set;
      if (req.valid && req.ready) rd_ff <= mem[set_in];
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         rsp.valid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SI'(NS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req.valid) begin
               set_ff   <= set_in;
               tag_ff   <= TB'(addr_m >> (LB + SB));
               core_ff  <= req.core_id;
               wr_ff    <= (req.opcode == OP_WRITE);
               state_ff <= S_LOOK;
            end
            S_LOOK: begin
               rsp.valid             <= 1'b1;
               rsp.hit               <= hit_c;
               rsp.way_used          <= 3'(way_c);
               rsp.writeback_valid   <= wb_c;
               rsp.writeback_address <= wb_addr_c;
               rsp.writeback_core    <= wb_c ? rd_ff[way_c].owner : 4'd0;
               rsp.fill_valid        <= !hit_c;
               rsp.fill_address      <= fill_addr_c;
               rsp.latency           <= lat_c;
               state_ff              <= S_RESP;
            end
            S_RESP: if (rsp.ready) begin
               rsp.valid <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `SACT_ASSERT_IMP(a_rsp_only_in_resp, rsp.valid, state_ff == S_RESP)
   `SACT_ASSERT_IMP(a_fill_xor_hit, rsp.valid, rsp.fill_valid != rsp.hit)
   `SACT_ASSERT_IMP(a_wb_only_miss, rsp.valid && rsp.writeback_valid, !rsp.hit)
   `SACT_ASSERT_NXT(a_accept_to_look, req.valid && req.ready, state_ff == S_LOOK)
endmodule
`default_nettype wire

FILE: design/set_assoc_cache_tag_controller.sv
// Top level of the set-associative write-back cache tag controller.
// Depends on sact_pkg, sact_if, sact_csr and sact_pipe.
// One request at a time: on acceptance the set is read from the set memory into
// a register; in the lookup state all ways are compared, the victim is picked,
// the set is written back and the response is registered; the next request is
// taken once the response leaves. After reset the set memory is cleared one set
// per cycle while no request is accepted.
`default_nettype none
module set_assoc_cache_tag_controller
   import sact_pkg::*;
#(
   parameter int SETS       = 64,
   parameter int WAYS       = 8,
   parameter int LINE_BYTES = 64,
   parameter int ADDR_BITS  = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   sact_req_if.sink         req,
   sact_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   lat_cfg_type cfg;

   sact_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg
   );

   sact_pipe #(.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES),
      .ADDR_BITS(ADDR_BITS)) u_pipe (
      .clock, .reset, .cfg, .req, .rsp
   );
endmodule
`default_nettype wire

FILE: tb/tb_set_assoc_cache_tag_controller.sv
// Self-checking testbench for the set-associative cache tag controller.
// Predicts hit, victim, writeback, fill and latency for every request.
// Depends on sact_pkg, sact_if and the set_assoc_cache_tag_controller RTL.
module tb_set_assoc_cache_tag_controller;
   import sact_pkg::*;

   localparam int NSETS = 64;
   localparam int NWAYS = 8;
   localparam int OFS_BITS = 6;
   localparam int IDX_BITS = 6;
   localparam int RANDOM_PER_PHASE = 380;

   typedef struct packed {
      logic        hit;
      logic [2:0]  way_used;
      logic        writeback_valid;
      logic [47:0] writeback_address;
      logic [3:0]  writeback_core;
      logic        fill_valid;
      logic [47:0] fill_address;
      logic [10:0] latency;
   } access_result_t;

   // tag directory predictor plus queue of predicted responses
   class cache_tag_scoreboard;
      bit [35:0]      tags[NSETS][NWAYS];
      bit [3:0]       owners[NSETS][NWAYS];
      line_state_type states[NSETS][NWAYS];
      bit [2:0]       ranks[NSETS][NWAYS];
      bit [9:0]       read_lat;
      bit [9:0]       write_lat;
      bit [9:0]       miss_pen;
      access_result_t pending[$];
      int             errors;

      function new();
         read_lat  = RESET_READ_LAT;
         write_lat = RESET_WRITE_LAT;
         miss_pen  = RESET_MISS_PEN;
         errors    = 0;
         for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < NWAYS; w++) begin
               tags[s][w]   = '0;
               owners[s][w] = '0;
               states[s][w] = ST_INVALID;
               ranks[s][w]  = w[2:0];
            end
      endfunction

      function void set_reg(logic [1:0] idx, bit [9:0] value);
         case (idx)
            REG_READ_LAT: begin
               read_lat = value;
            end
            REG_WRITE_LAT: begin
               write_lat = value;
            end
            REG_MISS_PEN: begin
               miss_pen = value;
            end
            default: begin
            end
         endcase
      endfunction

      // predict the response of an accepted request and update the directory
      function void note_request(bit [3:0] core, bit [47:0] addr, logic op);
         access_result_t res;
         int             set;
         bit [35:0]      tag;
         int             way;
         bit             found;
         bit [2:0]       old_rank;
         set   = addr[OFS_BITS +: IDX_BITS];
         tag   = addr[47:OFS_BITS+IDX_BITS];
         res   = '0;
         way   = 0;
         found = 0;
         // lowest matching way wins
         for (int w = 0; w < NWAYS; w++)
            if (!res.hit && states[set][w] != ST_INVALID && tags[set][w] == tag
                && owners[set][w] == core) begin
               res.hit = 1'b1;
               way = w;
            end
         if (!res.hit) begin
            for (int w = 0; w < NWAYS; w++)
               if (!found && states[set][w] == ST_INVALID) begin
                  way = w;
                  found = 1;
               end
            for (int w = 0; w < NWAYS; w++)
               if (!found && ranks[set][w] == 0) begin
                  way = w;
                  found = 1;
               end
            if (states[set][way] == ST_DIRTY) begin
               res.writeback_valid   = 1'b1;
               res.writeback_address = {tags[set][way], set[IDX_BITS-1:0],
                                        {OFS_BITS{1'b0}}};
               res.writeback_core    = owners[set][way];
            end
            tags[set][way]   = tag;
            owners[set][way] = core;
            states[set][way] = (op == OP_WRITE) ? ST_DIRTY : ST_CLEAN;
            res.fill_valid   = 1'b1;
            res.fill_address = {addr[47:OFS_BITS], {OFS_BITS{1'b0}}};
         end else if (op == OP_WRITE) begin
            states[set][way] = ST_DIRTY;
         end
         // true LRU: used way becomes MRU
         old_rank = ranks[set][way];
         for (int w = 0; w < NWAYS; w++)
            if (ranks[set][w] > old_rank)
               ranks[set][w]--;
         ranks[set][way] = 3'(NWAYS - 1);
         res.way_used = way[2:0];
         res.latency  = {1'b0, (op == OP_WRITE) ? write_lat : read_lat}
                        + (res.hit ? 11'd0 : {1'b0, miss_pen});
         pending.insert(pending.size(), res);
      endfunction

      function void check_response(access_result_t got);
         access_result_t want;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0h, got %0h", want.hit, got.hit);
            errors++;
         end
         if (got.way_used !== want.way_used) begin
            $error("way_used: expected %0h, got %0h", want.way_used, got.way_used);
            errors++;
         end
         if (got.writeback_valid !== want.writeback_valid) begin
            $error("writeback_valid: expected %0h, got %0h", want.writeback_valid,
                   got.writeback_valid);
            errors++;
         end
         if (got.writeback_address !== want.writeback_address) begin
            $error("writeback_address: expected %0h, got %0h",
                   want.writeback_address, got.writeback_address);
            errors++;
         end
         if (got.writeback_core !== want.writeback_core) begin
            $error("writeback_core: expected %0h, got %0h", want.writeback_core,
                   got.writeback_core);
            errors++;
         end
         if (got.fill_valid !== want.fill_valid) begin
            $error("fill_valid: expected %0h, got %0h", want.fill_valid, got.fill_valid);
            errors++;
         end
         if (got.fill_address !== want.fill_address) begin
            $error("fill_address: expected %0h, got %0h", want.fill_address,
                   got.fill_address);
            errors++;
         end
         if (got.latency !== want.latency) begin
            $error("latency: expected %0d, got %0d", want.latency, got.latency);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sact_req_if req ();
   sact_rsp_if rsp ();

   set_assoc_cache_tag_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cache_tag_scoreboard sb = new();
   bit [35:0] tag_pool[12];
   int        burst_left = 0;
   int        stall_mode = 0;
   int        stall_count = 0;

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.core_id = '0;
      req.byte_address = '0;
      req.opcode = OP_READ;
      rsp.ready = 1'b0;
   end

   // monitor: note accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            sb.note_request(req.core_id, req.byte_address, req.opcode);
         if (rsp.valid && rsp.ready)
            sb.check_response({rsp.hit, rsp.way_used, rsp.writeback_valid,
                               rsp.writeback_address, rsp.writeback_core,
                               rsp.fill_valid, rsp.fill_address, rsp.latency});
      end
   end

   // response backpressure in one of four randomly chosen modes
   always @(negedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 64 == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: begin
            rsp.ready <= 1'b1;
         end
         1: begin
            rsp.ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp.ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp.ready <= (stall_count % 16) < 10;
         end
      endcase
   end

   // called at a falling edge, returns at a falling edge after acceptance
   task automatic send_access(bit [3:0] core, bit [47:0] addr, logic op);
      if (burst_left == 0) begin
         if (req.valid) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      burst_left--;
      req.valid        <= 1'b1;
      req.core_id      <= core;
      req.byte_address <= addr;
      req.opcode       <= op;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, bit [9:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {22'($urandom_range(0, 4194303)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   // drain outstanding responses, then program all latency registers
   task automatic set_latencies(bit [9:0] rd, bit [9:0] wr, bit [9:0] pen);
      req.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write(REG_READ_LAT, rd);
      csr_write(REG_WRITE_LAT, wr);
      csr_write(REG_MISS_PEN, pen);
   endtask

   // mostly a few sets and tags so hits and evictions are common
   task automatic random_access();
      bit [47:0] addr;
      bit [3:0]  core;
      bit [5:0]  set;
      if ($urandom_range(0, 9) < 8) begin
         set = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 2));
         addr = {tag_pool[$urandom_range(0, 11)], set, 6'($urandom_range(0, 63))};
      end else begin
         addr = 48'({$urandom, $urandom});
      end
      core = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 2));
      send_access(core, addr, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 12; i++)
         tag_pool[i] = 36'({$urandom, $urandom});
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: miss, hit, same tag other owner, write hit, extremes
      send_access(4'd0, 48'h0, OP_READ);
      send_access(4'd0, 48'h3f, OP_READ);
      send_access(4'd15, 48'h0, OP_WRITE);
      send_access(4'd0, 48'h0, OP_WRITE);
      send_access(4'd15, 48'hffff_ffff_ffff, OP_WRITE);
      send_access(4'd15, 48'hffff_ffff_ffc0, OP_READ);
      send_access(4'd3, 48'hffff_ffff_ffff, OP_READ);
      // overfill set 0: dirty and clean victims picked by LRU
      for (int t = 1; t <= 12; t++)
         send_access(t[3:0], {36'(t), 6'd0, 6'd0}, t[0]);
      send_access(4'd0, 48'h0, OP_READ);
      send_access(4'd15, 48'h0, OP_READ);

      // several latency settings, extremes included
      set_latencies(10'd0, 10'd0, 10'd0);
      repeat (RANDOM_PER_PHASE) random_access();
      set_latencies(10'd1023, 10'd1023, 10'd1023);
      repeat (RANDOM_PER_PHASE) random_access();
      set_latencies(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                    10'($urandom_range(0, 1023)));
      repeat (RANDOM_PER_PHASE) random_access();
      set_latencies(10'd1023, 10'd0, 10'd512);
      repeat (RANDOM_PER_PHASE) random_access();
      set_latencies(10'd5, 10'd1000, 10'd1023);
      repeat (RANDOM_PER_PHASE) random_access();

      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
